// ===== hdl/pfps_pkg.sv =====
`default_nettype none

package pfps_pkg;

   localparam int SLOTS        = 32;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int COUNT_W      = $clog2(SLOTS + 1);
   localparam int PID_W        = 16;
   localparam int PRIO_W       = 5;
   localparam int QUANTUM_W    = 9;
   localparam int BASE_W       = 8;
   localparam int TOP_PRIORITY = 31;
   localparam int PRIO_LIMIT   = (1 << PRIO_W) - 1;
   localparam int PRIO_WEIGHT  = 3;
   localparam int QUANTUM_MAX  = (1 << QUANTUM_W) - 1;

   // Priority of slot 0 after reset, clipped to the priority field.
   localparam logic [PRIO_W-1:0] PRIO_RESET =
      PRIO_W'((TOP_PRIORITY > PRIO_LIMIT) ? PRIO_LIMIT : TOP_PRIORITY);
   localparam logic [BASE_W-1:0] BASE_QUANTUM_RESET = BASE_W'(10);

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_W = 24;
   localparam int RSP_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_BASE_QUANTUM = 1'b0;

   typedef enum logic [1:0] {
      CMD_CREATE   = 2'd0,
      CMD_CHANGE   = 2'd1,
      CMD_SCHEDULE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_REJECTED  = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CH_SCAN,
      ST_SC_SCAN,
      ST_SC_SHIFT,
      ST_SC_PID,
      ST_EMIT
   } state_type;

   function automatic logic [QUANTUM_W-1:0] quantum_for(input logic [BASE_W-1:0] base,
                                                         input logic [PRIO_W-1:0] prio);
      logic [QUANTUM_W:0] sum;
      sum = (QUANTUM_W+1)'(base) +
            (QUANTUM_W+1)'(prio) * (QUANTUM_W+1)'(PRIO_WEIGHT);
      if (sum > (QUANTUM_W+1)'(QUANTUM_MAX)) begin
         return QUANTUM_W'(QUANTUM_MAX);
      end
      return sum[QUANTUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/priority_fifo_process_scheduler.sv =====
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  cmd, pid, priority_req
// rsp      out        rsp_tvalid/rsp_tready  status, slot, running_pid, running_priority, quantum
// csr      in         APB, pready tied high  base_quantum at byte address 0
//
// Create and unused commands go through the decode and emit states to the registered result.
// Change scans the used slots through the pid memory read port.
// Schedule scans the ready queue through two chained memory reads,
// then compacts the queue one entry a cycle.
// After reset the init state writes slot 0 before the first item is accepted.
// A finished result waits in the output register while the next item is accepted.

module priority_fifo_process_scheduler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [1:0] cmd, [17:2] pid, [22:18] priority_req, [23] zero
   input  wire logic [pfps_pkg::REQ_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] status, [6:2] slot, [22:7] running_pid, [27:23] running_priority,
   // [36:28] quantum, [39:37] zero
   output logic [pfps_pkg::RSP_W-1:0]             rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pfps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pfps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pfps_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int SW = pfps_pkg::SLOT_W;
   localparam int CW = pfps_pkg::COUNT_W;
   localparam int PW = pfps_pkg::PRIO_W;
   localparam int DW = pfps_pkg::PID_W;
   localparam int QW = pfps_pkg::QUANTUM_W;
   localparam int BW = pfps_pkg::BASE_W;
   localparam int CSR_ADDR_W_TOP = pfps_pkg::CSR_ADDR_W - 1;

   // Slot and queue stores.
   logic [DW-1:0] pid_mem   [pfps_pkg::SLOTS];
   logic [PW-1:0] prio_mem  [pfps_pkg::SLOTS];
   logic [SW-1:0] order_mem [pfps_pkg::SLOTS];

   logic          pid_we;
   logic [SW-1:0] pid_waddr;
   logic [DW-1:0] pid_wdata;
   logic [SW-1:0] pid_raddr;
   logic [DW-1:0] pid_rdata_ff;

   logic          prio_we;
   logic [SW-1:0] prio_waddr;
   logic [PW-1:0] prio_wdata;
   logic [SW-1:0] prio_raddr;
   logic [PW-1:0] prio_rdata_ff;

   logic          order_we;
   logic [SW-1:0] order_waddr;
   logic [SW-1:0] order_wdata;
   logic [SW-1:0] order_raddr;
   logic [SW-1:0] order_rdata_ff;

   pfps_pkg::state_type  state_ff, state_in;
   logic [BW-1:0]        base_quantum_ff;
   logic [CW-1:0]        ready_count_ff, ready_count_in;
   logic [CW-1:0]        slots_used_ff, slots_used_in;
   logic [SW-1:0]        running_slot_ff, running_slot_in;
   logic [DW-1:0]        running_pid_ff, running_pid_in;
   logic [PW-1:0]        running_prio_ff, running_prio_in;
   logic [QW-1:0]        running_quantum_ff, running_quantum_in;

   pfps_pkg::cmd_type    cmd_ff, cmd_in;
   logic [DW-1:0]        pid_ff, pid_in;
   logic [PW-1:0]        prio_ff, prio_in;

   logic [CW-1:0]        issue_idx_ff, issue_idx_in;
   logic                 a_vld_ff, a_vld_in;
   logic [SW-1:0]        a_idx_ff, a_idx_in;
   logic                 b_vld_ff, b_vld_in;
   logic [SW-1:0]        b_idx_ff, b_idx_in;
   logic [SW-1:0]        b_slot_ff, b_slot_in;
   logic                 have_ff, have_in;
   logic [PW-1:0]        best_prio_ff, best_prio_in;
   logic [SW-1:0]        best_idx_ff, best_idx_in;
   logic [SW-1:0]        best_slot_ff, best_slot_in;

   pfps_pkg::status_type res_status_ff, res_status_in;
   logic [SW-1:0]        res_slot_ff, res_slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [pfps_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic csr_write;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W_TOP] == pfps_pkg::CSR_IDX_BASE_QUANTUM) begin
         csr_prdata = pfps_pkg::CSR_DATA_W'(base_quantum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_quantum_ff <= pfps_pkg::BASE_QUANTUM_RESET;
      end else if (csr_write &&
                   csr_paddr[CSR_ADDR_W_TOP] == pfps_pkg::CSR_IDX_BASE_QUANTUM) begin
         base_quantum_ff <= csr_pwdata[BW-1:0];
      end
   end

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (pid_we) begin
         pid_mem[pid_waddr] <= pid_wdata;
      end
      pid_rdata_ff <= pid_mem[pid_raddr];
   end

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[prio_waddr] <= prio_wdata;
      end
      prio_rdata_ff <= prio_mem[prio_raddr];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rdata_ff <= order_mem[order_raddr];
   end

   // Read addresses follow the sequencer.
   assign order_raddr = issue_idx_ff[SW-1:0];
   assign pid_raddr   = (state_ff == pfps_pkg::ST_SC_SHIFT) ? best_slot_ff
                                                            : issue_idx_ff[SW-1:0];
   assign prio_raddr  = (state_ff == pfps_pkg::ST_SC_SCAN) ? order_rdata_ff
                                                           : issue_idx_ff[SW-1:0];

   assign req_tready = (state_ff == pfps_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= pfps_pkg::ST_INIT;
         ready_count_ff     <= '0;
         slots_used_ff      <= CW'(1);
         running_slot_ff    <= '0;
         running_pid_ff     <= '0;
         running_prio_ff    <= pfps_pkg::PRIO_RESET;
         running_quantum_ff <= pfps_pkg::quantum_for(pfps_pkg::BASE_QUANTUM_RESET, '0);
         a_vld_ff           <= 1'b0;
         b_vld_ff           <= 1'b0;
         have_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         ready_count_ff     <= ready_count_in;
         slots_used_ff      <= slots_used_in;
         running_slot_ff    <= running_slot_in;
         running_pid_ff     <= running_pid_in;
         running_prio_ff    <= running_prio_in;
         running_quantum_ff <= running_quantum_in;
         a_vld_ff           <= a_vld_in;
         b_vld_ff           <= b_vld_in;
         have_ff            <= have_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      prio_ff       <= prio_in;
      issue_idx_ff  <= issue_idx_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      b_slot_ff     <= b_slot_in;
      best_prio_ff  <= best_prio_in;
      best_idx_ff   <= best_idx_in;
      best_slot_ff  <= best_slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      logic          issue;
      logic          take;
      logic          out_free;
      logic [SW-1:0] pick_idx;

      state_in           = state_ff;
      ready_count_in     = ready_count_ff;
      slots_used_in      = slots_used_ff;
      running_slot_in    = running_slot_ff;
      running_pid_in     = running_pid_ff;
      running_prio_in    = running_prio_ff;
      running_quantum_in = running_quantum_ff;
      cmd_in             = cmd_ff;
      pid_in             = pid_ff;
      prio_in            = prio_ff;
      issue_idx_in       = issue_idx_ff;
      a_vld_in           = 1'b0;
      a_idx_in           = a_idx_ff;
      b_vld_in           = 1'b0;
      b_idx_in           = b_idx_ff;
      b_slot_in          = b_slot_ff;
      have_in            = have_ff;
      best_prio_in       = best_prio_ff;
      best_idx_in        = best_idx_ff;
      best_slot_in       = best_slot_ff;
      res_status_in      = res_status_ff;
      res_slot_in        = res_slot_ff;
      rsp_data_in        = rsp_data_ff;

      pid_we      = 1'b0;
      pid_waddr   = slots_used_ff[SW-1:0];
      pid_wdata   = pid_ff;
      prio_we     = 1'b0;
      prio_waddr  = slots_used_ff[SW-1:0];
      prio_wdata  = prio_ff;
      order_we    = 1'b0;
      order_waddr = ready_count_ff[SW-1:0];
      order_wdata = slots_used_ff[SW-1:0];

      issue    = 1'b0;
      take     = !have_ff || (prio_rdata_ff > best_prio_ff);
      out_free = !rsp_valid_ff || rsp_tready;
      pick_idx = take ? b_idx_ff : best_idx_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      case (state_ff)
         pfps_pkg::ST_INIT: begin
            // Slot 0 holds pid 0 at the top priority after reset.
            pid_we     = 1'b1;
            pid_waddr  = '0;
            pid_wdata  = '0;
            prio_we    = 1'b1;
            prio_waddr = '0;
            prio_wdata = pfps_pkg::PRIO_RESET;
            state_in   = pfps_pkg::ST_IDLE;
         end

         pfps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = pfps_pkg::cmd_type'(req_tdata[1:0]);
               pid_in   = req_tdata[DW+1:2];
               prio_in  = req_tdata[DW+PW+1:DW+2];
               state_in = pfps_pkg::ST_DECODE;
            end
         end

         pfps_pkg::ST_DECODE: begin
            issue_idx_in = '0;
            have_in      = 1'b0;
            case (cmd_ff)
               pfps_pkg::CMD_CREATE: begin
                  if (slots_used_ff >= CW'(pfps_pkg::SLOTS) ||
                      ready_count_ff >= CW'(pfps_pkg::SLOTS)) begin
                     res_status_in = pfps_pkg::STATUS_FULL;
                     res_slot_in   = '0;
                  end else begin
                     pid_we         = 1'b1;
                     prio_we        = 1'b1;
                     order_we       = 1'b1;
                     slots_used_in  = slots_used_ff + CW'(1);
                     ready_count_in = ready_count_ff + CW'(1);
                     res_status_in  = pfps_pkg::STATUS_OK;
                     res_slot_in    = slots_used_ff[SW-1:0];
                  end
                  state_in = pfps_pkg::ST_EMIT;
               end
               pfps_pkg::CMD_CHANGE: begin
                  state_in = pfps_pkg::ST_CH_SCAN;
               end
               pfps_pkg::CMD_SCHEDULE: begin
                  // The running process rejoins the tail of the queue first, if the queue has room.
                  if (ready_count_ff < CW'(pfps_pkg::SLOTS)) begin
                     order_we       = 1'b1;
                     order_wdata    = running_slot_ff;
                     ready_count_in = ready_count_ff + CW'(1);
                  end
                  state_in = pfps_pkg::ST_SC_SCAN;
               end
               default: begin
                  res_status_in = pfps_pkg::STATUS_OK;
                  res_slot_in   = running_slot_ff;
                  state_in      = pfps_pkg::ST_EMIT;
               end
            endcase
         end

         pfps_pkg::ST_CH_SCAN: begin
            // One slot read issued per cycle; compare in the cycle after.
            issue        = issue_idx_ff < slots_used_ff;
            issue_idx_in = issue_idx_ff + CW'(issue);
            a_vld_in     = issue;
            a_idx_in     = issue_idx_ff[SW-1:0];
            if (a_vld_ff && pid_rdata_ff == pid_ff) begin
               res_slot_in = a_idx_ff;
               if (prio_ff < prio_rdata_ff) begin
                  res_status_in = pfps_pkg::STATUS_REJECTED;
               end else begin
                  res_status_in = pfps_pkg::STATUS_OK;
                  prio_we       = 1'b1;
                  prio_waddr    = a_idx_ff;
                  if (a_idx_ff == running_slot_ff) begin
                     running_prio_in    = prio_ff;
                     running_quantum_in = pfps_pkg::quantum_for(base_quantum_ff, prio_ff);
                  end
               end
               a_vld_in = 1'b0;
               state_in = pfps_pkg::ST_EMIT;
            end else if (a_vld_ff && {1'b0, a_idx_ff} == slots_used_ff - CW'(1)) begin
               res_status_in = pfps_pkg::STATUS_NOT_FOUND;
               res_slot_in   = '0;
               a_vld_in      = 1'b0;
               state_in      = pfps_pkg::ST_EMIT;
            end
         end

         pfps_pkg::ST_SC_SCAN: begin
            // Stage A reads the queue entry, stage B its slot priority,
            // stage C keeps the first highest one.
            issue        = issue_idx_ff < ready_count_ff;
            issue_idx_in = issue_idx_ff + CW'(issue);
            a_vld_in     = issue;
            a_idx_in     = issue_idx_ff[SW-1:0];
            b_vld_in     = a_vld_ff;
            b_idx_in     = a_idx_ff;
            b_slot_in    = order_rdata_ff;
            if (b_vld_ff) begin
               if (take) begin
                  have_in      = 1'b1;
                  best_prio_in = prio_rdata_ff;
                  best_idx_in  = b_idx_ff;
                  best_slot_in = b_slot_ff;
               end
               if ({1'b0, b_idx_ff} == ready_count_ff - CW'(1)) begin
                  issue_idx_in = {1'b0, pick_idx} + CW'(1);
                  a_vld_in     = 1'b0;
                  b_vld_in     = 1'b0;
                  state_in     = pfps_pkg::ST_SC_SHIFT;
               end
            end
         end

         pfps_pkg::ST_SC_SHIFT: begin
            // Close the gap: each entry after the chosen one moves down by one.
            issue        = issue_idx_ff < ready_count_ff;
            issue_idx_in = issue_idx_ff + CW'(issue);
            a_vld_in     = issue;
            a_idx_in     = issue_idx_ff[SW-1:0];
            if (a_vld_ff) begin
               order_we    = 1'b1;
               order_waddr = a_idx_ff - SW'(1);
               order_wdata = order_rdata_ff;
            end
            if (!issue && !a_vld_ff) begin
               state_in = pfps_pkg::ST_SC_PID;
            end
         end

         pfps_pkg::ST_SC_PID: begin
            ready_count_in     = ready_count_ff - CW'(1);
            running_slot_in    = best_slot_ff;
            running_pid_in     = pid_rdata_ff;
            running_prio_in    = best_prio_ff;
            running_quantum_in = pfps_pkg::quantum_for(base_quantum_ff, best_prio_ff);
            res_status_in      = pfps_pkg::STATUS_OK;
            res_slot_in        = best_slot_ff;
            state_in           = pfps_pkg::ST_EMIT;
         end

         pfps_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pfps_pkg::RSP_W'({running_quantum_ff, running_prio_ff,
                                                running_pid_ff, res_slot_ff,
                                                res_status_ff});
               state_in     = pfps_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/pfps_checker.sv =====
`default_nettype none

module pfps_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [pfps_pkg::REQ_W-1:0]        req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [pfps_pkg::RSP_W-1:0]        rsp_tdata,
   input wire logic                              csr_psel,
   input wire logic                              csr_penable,
   input wire logic                              csr_pwrite,
   input wire logic [pfps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input wire logic [pfps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input wire logic [pfps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input wire logic                              csr_pready
);

   localparam int SLOT_LO = 2;
   localparam int SLOT_HI = SLOT_LO + pfps_pkg::SLOT_W - 1;

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Pool full and unknown pid report slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == pfps_pkg::STATUS_FULL ||
                     rsp_tdata[1:0] == pfps_pkg::STATUS_NOT_FOUND)
      |-> rsp_tdata[SLOT_HI:SLOT_LO] == '0)
      else $error("failed command reports a non-zero slot");

   // One item at a time: the block is busy the cycle after it takes an item.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   // Nothing is offered straight out of reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind priority_fifo_process_scheduler pfps_checker u_pfps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

`default_nettype wire
